/* hdl/brl_pkg.sv */
// Shared constants for the Bresenham line rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

    // Default coordinate width; the top level may override it.
    localparam int DEF_COORD_BITS = 12;

    // Fixed field widths.
    localparam int VIEW_BITS    = 12;
    localparam int COLOR_BITS   = 24;
    localparam int CFG_IDX_BITS = 1;

    // Viewport size after reset.
    localparam logic [VIEW_BITS-1:0] VIEW_WIDTH_RESET  = 12'd640;
    localparam logic [VIEW_BITS-1:0] VIEW_HEIGHT_RESET = 12'd480;

    // Request codes carried by req_type.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_HEIGHT = 1'd1;

endpackage

/* hdl/brl_skid.sv */
// Two-entry output buffer that decouples the pixel producer from the receiver.
`timescale 1ns / 1ps

module brl_skid #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              in_fire;

    // Ready comes straight from a register, so it never depends on out_ready.
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_ready) begin
                // The output slot frees up: refill from the skid entry first.
                if (skid_valid_reg) begin
                    out_data_reg   <= skid_data_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_data_reg  <= in_data;
                    out_valid_reg <= in_fire;
                end
            end else if (in_fire) begin
                // Output is stalled: park the new item in the skid entry.
                skid_data_reg  <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

/* hdl/bresenham_line_rasterizer.sv */
// Top level of the Bresenham line rasterizer: setup, stepping and configuration.
`timescale 1ns / 1ps

// Usage:
// The input channel (s_*) takes two kinds of item. A load item (req_type low)
// brings two endpoints and a colour; the block picks the major axis, orders
// the endpoints and primes the error term. A load gives no result. A step
// item (req_type high) emits one pixel on the result channel (m_*) while a
// line is active, with its colour, a viewport flag and a last mark on the
// final pixel; a step with no active line gives nothing. The far endpoint on
// the major axis is not drawn, so a run of length n gives n pixels.
// Each pixel is registered in the output buffer before it reaches m_valid. One
// item is taken in every cycle while s_ready is high; each step works from registers.
// A two-entry output buffer sits before m_*, so when the receiver stalls one
// more item is still taken, after which s_ready drops until a pixel drains.
// The user must write the viewport registers via cfg_we/cfg_addr/cfg_wdata only
// while the block is idle; the block does not enforce this. Reset ends any
// active line, empties the output buffer and sets the viewport to 640 by 480.

module bresenham_line_rasterizer #(
    parameter int COORD_BITS = brl_pkg::DEF_COORD_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration port.
    input  logic                               cfg_we,
    input  logic [brl_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
    input  logic [brl_pkg::VIEW_BITS-1:0]      cfg_wdata,
    // Request channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic signed [COORD_BITS-1:0]       s_from_x,
    input  logic signed [COORD_BITS-1:0]       s_from_y,
    input  logic signed [COORD_BITS-1:0]       s_to_x,
    input  logic signed [COORD_BITS-1:0]       s_to_y,
    input  logic [brl_pkg::COLOR_BITS-1:0]     s_line_color,
    // Pixel channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [COORD_BITS-1:0]       m_pixel_x,
    output logic signed [COORD_BITS-1:0]       m_pixel_y,
    output logic [brl_pkg::COLOR_BITS-1:0]     m_pixel_color,
    output logic                               m_in_view,
    output logic                               m_last
);

    import brl_pkg::*;

    localparam int EXT_W = COORD_BITS + 1;
    localparam int CMP_W = ((COORD_BITS > VIEW_BITS) ? COORD_BITS : VIEW_BITS) + 1;
    localparam int PIX_W = 2 * COORD_BITS + COLOR_BITS + 2;

    // Configuration registers.
    logic [VIEW_BITS-1:0] view_width_reg;
    logic [VIEW_BITS-1:0] view_height_reg;

    // Line state.
    logic                         busy_reg;
    logic                         steep_reg;
    logic signed [COORD_BITS-1:0] run_pos_reg;
    logic signed [COORD_BITS-1:0] run_end_reg;
    logic signed [COORD_BITS-1:0] cross_pos_reg;
    logic                         cross_dir_reg;
    logic [COORD_BITS-1:0]        run_len_reg;
    logic [COORD_BITS-1:0]        cross_len_reg;
    logic signed [EXT_W-1:0]      err_acc_reg;
    logic [COLOR_BITS-1:0]        held_color_reg;

    logic s_fire;
    logic load_fire;
    logic step_fire;

    // Load setup.
    logic signed [EXT_W-1:0]      ld_dx;
    logic signed [EXT_W-1:0]      ld_dy;
    logic [COORD_BITS-1:0]        ld_adx;
    logic [COORD_BITS-1:0]        ld_ady;
    logic                         ld_steep;
    logic signed [COORD_BITS-1:0] ld_a_run;
    logic signed [COORD_BITS-1:0] ld_a_cross;
    logic signed [COORD_BITS-1:0] ld_b_run;
    logic signed [COORD_BITS-1:0] ld_b_cross;
    logic                         ld_swap;
    logic signed [COORD_BITS-1:0] ld_run0;
    logic signed [COORD_BITS-1:0] ld_run1;
    logic signed [COORD_BITS-1:0] ld_cross0;
    logic signed [COORD_BITS-1:0] ld_cross1;
    logic [COORD_BITS-1:0]        ld_run_len;
    logic [COORD_BITS-1:0]        ld_cross_len;

    // Step datapath.
    logic signed [COORD_BITS-1:0] st_px;
    logic signed [COORD_BITS-1:0] st_py;
    logic signed [CMP_W-1:0]      st_px_w;
    logic signed [CMP_W-1:0]      st_py_w;
    logic signed [CMP_W-1:0]      st_vw_w;
    logic signed [CMP_W-1:0]      st_vh_w;
    logic                         st_in_view;
    logic signed [EXT_W-1:0]      st_run_inc;
    logic                         st_fin;
    logic signed [EXT_W-1:0]      st_err_sub;
    logic signed [EXT_W-1:0]      st_err_fix;

    logic             pix_ready;
    logic [PIX_W-1:0] pix_data;
    logic [PIX_W-1:0] out_data;

    assign s_ready   = pix_ready;
    assign s_fire    = s_valid && s_ready;
    assign load_fire = s_fire && (s_req_type == REQ_LOAD);
    assign step_fire = s_fire && (s_req_type == REQ_STEP) && busy_reg;

    // Line setup: the major axis is the one with the larger extent, and the
    // endpoints are ordered so that the run coordinate increases.
    always_comb begin
        ld_dx  = EXT_W'(s_to_x) - EXT_W'(s_from_x);
        ld_dy  = EXT_W'(s_to_y) - EXT_W'(s_from_y);
        ld_adx = ld_dx[EXT_W-1] ? COORD_BITS'(-ld_dx) : ld_dx[COORD_BITS-1:0];
        ld_ady = ld_dy[EXT_W-1] ? COORD_BITS'(-ld_dy) : ld_dy[COORD_BITS-1:0];
        ld_steep = ld_ady > ld_adx;

        ld_a_run   = ld_steep ? s_from_y : s_from_x;
        ld_a_cross = ld_steep ? s_from_x : s_from_y;
        ld_b_run   = ld_steep ? s_to_y   : s_to_x;
        ld_b_cross = ld_steep ? s_to_x   : s_to_y;

        ld_swap   = ld_a_run > ld_b_run;
        ld_run0   = ld_swap ? ld_b_run   : ld_a_run;
        ld_run1   = ld_swap ? ld_a_run   : ld_b_run;
        ld_cross0 = ld_swap ? ld_b_cross : ld_a_cross;
        ld_cross1 = ld_swap ? ld_a_cross : ld_b_cross;

        ld_run_len   = ld_steep ? ld_ady : ld_adx;
        ld_cross_len = ld_steep ? ld_adx : ld_ady;
    end

    // One step: emit the current pixel, then advance along the run and move
    // the cross coordinate when the error term goes negative.
    always_comb begin
        st_px = steep_reg ? cross_pos_reg : run_pos_reg;
        st_py = steep_reg ? run_pos_reg   : cross_pos_reg;

        // Viewport clip in a common width; negative coordinates are outside.
        st_px_w    = CMP_W'(st_px);
        st_py_w    = CMP_W'(st_py);
        st_vw_w    = $signed(CMP_W'(view_width_reg));
        st_vh_w    = $signed(CMP_W'(view_height_reg));
        st_in_view = !st_px_w[CMP_W-1] && (st_px_w < st_vw_w) &&
                     !st_py_w[CMP_W-1] && (st_py_w < st_vh_w);

        st_run_inc = EXT_W'(run_pos_reg) + EXT_W'(1);
        st_fin     = st_run_inc >= EXT_W'(run_end_reg);

        st_err_sub = err_acc_reg - $signed({1'b0, cross_len_reg});
        st_err_fix = st_err_sub + $signed({1'b0, run_len_reg});
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_width_reg  <= VIEW_WIDTH_RESET;
            view_height_reg <= VIEW_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_VIEW_WIDTH:  view_width_reg  <= cfg_wdata;
                CFG_VIEW_HEIGHT: view_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Line state: a load replaces any active line, a step advances it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load_fire) begin
            busy_reg <= ld_run_len != '0;
        end else if (step_fire && st_fin) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fire) begin
            steep_reg      <= ld_steep;
            run_pos_reg    <= ld_run0;
            run_end_reg    <= ld_run1;
            cross_pos_reg  <= ld_cross0;
            cross_dir_reg  <= ld_cross0 < ld_cross1;
            run_len_reg    <= ld_run_len;
            cross_len_reg  <= ld_cross_len;
            err_acc_reg    <= $signed({2'b00, ld_run_len[COORD_BITS-1:1]});
            held_color_reg <= s_line_color;
        end else if (step_fire) begin
            run_pos_reg <= st_run_inc[COORD_BITS-1:0];
            if (st_err_sub[EXT_W-1]) begin
                cross_pos_reg <= cross_dir_reg ? cross_pos_reg + COORD_BITS'(1)
                                               : cross_pos_reg - COORD_BITS'(1);
                err_acc_reg   <= st_err_fix;
            end else begin
                err_acc_reg <= st_err_sub;
            end
        end
    end

    assign pix_data = {st_px, st_py, held_color_reg, st_in_view, st_fin};

    brl_skid #(
        .DATA_W (PIX_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step_fire),
        .in_ready  (pix_ready),
        .in_data   (pix_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_pixel_x     = out_data[PIX_W-1 -: COORD_BITS];
    assign m_pixel_y     = out_data[PIX_W-COORD_BITS-1 -: COORD_BITS];
    assign m_pixel_color = out_data[COLOR_BITS+1:2];
    assign m_in_view     = out_data[1];
    assign m_last        = out_data[0];

    // The final pixel of a line always ends it.
    a_fin_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && st_fin && !load_fire) |=> !busy_reg)
        else $error("line still active after its last pixel");

    // The error term stays within [0, run length) while a line is active.
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (!err_acc_reg[EXT_W-1] &&
                      (err_acc_reg < $signed({1'b0, run_len_reg}))))
        else $error("error term out of range");

    // The run axis is the major axis.
    a_major_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cross_len_reg <= run_len_reg))
        else $error("cross extent exceeds run extent");

    // An active line has not yet reached its far endpoint.
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (run_pos_reg < run_end_reg))
        else $error("run position passed the line end");

endmodule

/* dv/bresenham_line_rasterizer_tb.sv */
// Self-checking testbench for the Bresenham line rasterizer: directed table, random lines.
`timescale 1ns / 1ps

// The testbench drives load and step items into the rasterizer and holds its
// own copy of the line state to predict every pixel. Predicted pixels wait in
// a queue and are matched, field by field, against each pixel that the block
// hands over. Both channels idle at random, except for one phase that runs
// with no idling at all. The viewport registers are rewritten between phases,
// once every predicted pixel has arrived, so that the clipping is tried at
// its extremes: one pixel, no pixel at all, the widest setting and a few
// uneven ones.
module bresenham_line_rasterizer_tb;
    import brl_pkg::*;

    localparam int CB            = DEF_COORD_BITS;
    localparam int CMIN          = -(1 << (CB - 1));
    localparam int CMAX          = (1 << (CB - 1)) - 1;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    // The block registers each pixel in an output buffer of two pixels, so a
    // handful of cycles covers anything still in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_QUOTA   = 115;
    localparam int DIRECTED_ROWS = 23;
    localparam int IDLE_PCT      = 34;

    // How a directed row is checked: against the predictor, against no pixel
    // at all, or against a pixel typed into the table.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } chk_e;

    typedef struct packed {
        logic                  req_type;
        logic signed [CB-1:0]  from_x;
        logic signed [CB-1:0]  from_y;
        logic signed [CB-1:0]  to_x;
        logic signed [CB-1:0]  to_y;
        logic [COLOR_BITS-1:0] line_color;
    } req_t;

    typedef struct packed {
        logic signed [CB-1:0]  x;
        logic signed [CB-1:0]  y;
        logic [COLOR_BITS-1:0] color;
        logic                  in_view;
        logic                  last;
    } pixel_t;

    typedef struct packed {
        req_t   req;
        chk_e   chk;
        pixel_t px;
    } dir_row_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr      = CFG_VIEW_WIDTH;
    logic [VIEW_BITS-1:0]    cfg_wdata     = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic                    s_req_type    = REQ_LOAD;
    logic signed [CB-1:0]    s_from_x      = '0;
    logic signed [CB-1:0]    s_from_y      = '0;
    logic signed [CB-1:0]    s_to_x        = '0;
    logic signed [CB-1:0]    s_to_y        = '0;
    logic [COLOR_BITS-1:0]   s_line_color  = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic signed [CB-1:0]    m_pixel_x;
    logic signed [CB-1:0]    m_pixel_y;
    logic [COLOR_BITS-1:0]   m_pixel_color;
    logic                    m_in_view;
    logic                    m_last;

    // Predictor copy of the viewport and of the line being drawn. The line
    // runs along its major axis; major_y marks a steep line whose major axis
    // is y, so x and y were swapped when it was loaded.
    logic [VIEW_BITS-1:0]    vp_width    = VIEW_WIDTH_RESET;
    logic [VIEW_BITS-1:0]    vp_height   = VIEW_HEIGHT_RESET;
    logic                    line_active = 1'b0;
    logic                    major_y     = 1'b0;
    logic signed [CB-1:0]    major_pos   = '0;
    logic signed [CB-1:0]    major_stop  = '0;
    logic signed [CB-1:0]    minor_pos   = '0;
    logic                    minor_up    = 1'b0;
    logic [CB-1:0]           major_span  = '0;
    logic [CB-1:0]           minor_span  = '0;
    logic signed [CB:0]      slope_err   = '0;
    logic [COLOR_BITS-1:0]   line_rgb    = '0;

    pixel_t   pixels_due[$];
    dir_row_t directed_rows[DIRECTED_ROWS];
    int       mismatches = 0;
    int       cycles     = 0;
    // Set for the one phase in which neither side idles.
    bit       steady     = 1'b0;

    bresenham_line_rasterizer #(
        .COORD_BITS(CB)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_from_x      (s_from_x),
        .s_from_y      (s_from_y),
        .s_to_x        (s_to_x),
        .s_to_y        (s_to_y),
        .s_line_color  (s_line_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_in_view     (m_in_view),
        .m_last        (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int fit(input int v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    // Advances the predicted line by one item. A load sets the line up and
    // gives nothing; a step gives one pixel while a line is active.
    function automatic bit trace_pixel(input req_t r, output pixel_t px);
        int ax, ay, bx, by, t, rp, cp, e, vx, vy;
        bit fin;
        px = '0;
        if (r.req_type == REQ_LOAD) begin
            ax = $signed(r.from_x);
            ay = $signed(r.from_y);
            bx = $signed(r.to_x);
            by = $signed(r.to_y);
            // Steep only when the y distance strictly wins; a diagonal runs
            // along x.
            major_y = span(by, ay) > span(bx, ax);
            if (major_y) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            major_pos  = ax[CB-1:0];
            major_stop = bx[CB-1:0];
            minor_pos  = ay[CB-1:0];
            minor_up   = ay < by;
            t = bx - ax;
            major_span = t[CB-1:0];
            line_active = t > 0;
            t = (bx - ax) / 2;
            slope_err = t[CB:0];
            t = span(by, ay);
            minor_span = t[CB-1:0];
            line_rgb = r.line_color;
            return 1'b0;
        end
        if (!line_active) return 1'b0;
        rp = $signed(major_pos);
        cp = $signed(minor_pos);
        vx = major_y ? cp : rp;
        vy = major_y ? rp : cp;
        // The far endpoint on the major axis is never drawn.
        fin = rp + 1 >= int'($signed(major_stop));
        px.x       = vx[CB-1:0];
        px.y       = vy[CB-1:0];
        px.color   = line_rgb;
        px.in_view = vx >= 0 && vx < int'(vp_width) && vy >= 0 && vy < int'(vp_height);
        px.last    = fin;
        e = int'($signed(slope_err)) - int'(minor_span);
        if (e < 0) begin
            cp = minor_up ? cp + 1 : cp - 1;
            e  = e + int'(major_span);
        end
        slope_err = e[CB:0];
        minor_pos = cp[CB-1:0];
        rp = rp + 1;
        major_pos = rp[CB-1:0];
        if (fin) line_active = 1'b0;
        return 1'b1;
    endfunction

    function automatic dir_row_t mk_row(input logic kind, input int fx, input int fy,
                                        input int tx, input int ty,
                                        input logic [COLOR_BITS-1:0] col, input chk_e chk,
                                        input int ex, input int ey,
                                        input logic [COLOR_BITS-1:0] ec,
                                        input logic ev, input logic el);
        dir_row_t row;
        row.req.req_type   = kind;
        row.req.from_x     = fx[CB-1:0];
        row.req.from_y     = fy[CB-1:0];
        row.req.to_x       = tx[CB-1:0];
        row.req.to_y       = ty[CB-1:0];
        row.req.line_color = col;
        row.chk            = chk;
        row.px.x           = ex[CB-1:0];
        row.px.y           = ey[CB-1:0];
        row.px.color       = ec;
        row.px.in_view     = ev;
        row.px.last        = el;
        return row;
    endfunction

    // Every field random; on a step item the endpoints and the colour are
    // ignored by the block, which gives their bits a workout for free.
    function automatic req_t any_req(input logic kind);
        logic [95:0] raw;
        req_t r;
        raw = {$urandom, $urandom, $urandom};
        r = raw[$bits(req_t)-1:0];
        r.req_type = kind;
        return r;
    endfunction

    // A coordinate close to a clipping edge or to the end of the range.
    function automatic int near_edge(input int lim);
        int v;
        case ($urandom_range(0, 6))
            0: v = 0;
            1: v = -1;
            2: v = lim - 1;
            3: v = lim;
            4: v = $urandom_range(0, lim);
            5: v = CMIN;
            default: v = CMAX;
        endcase
        return fit(v + int'($urandom_range(0, 6)) - 3);
    endfunction

    // Offers one item, records what it should produce at the edge that takes
    // it, then idles the sender now and then.
    task automatic issue(input req_t r, input chk_e chk, input pixel_t typed, output bit made);
        pixel_t guess;
        s_valid      <= 1'b1;
        s_req_type   <= r.req_type;
        s_from_x     <= r.from_x;
        s_from_y     <= r.from_y;
        s_to_x       <= r.to_x;
        s_to_y       <= r.to_y;
        s_line_color <= r.line_color;
        do @(posedge aclk); while (!s_ready);
        made = trace_pixel(r, guess);
        case (chk)
            CHK_MODEL: if (made) pixels_due.push_back(guess);
            CHK_PIXEL: pixels_due.push_back(typed);
            default: ;
        endcase
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Waits until every predicted pixel has come back, plus a few cycles for
    // a load that may still be on its way through.
    task automatic drain(input int extra);
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_viewport(input logic [VIEW_BITS-1:0] w, input logic [VIEW_BITS-1:0] h);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_VIEW_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        vp_width = w;
        cfg_addr  <= CFG_VIEW_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        vp_height = h;
        cfg_we <= 1'b0;
    endtask

    // Mostly whole lines: a load, then one step per pixel. Some lines are cut
    // short by the next load, some get extra steps after their last pixel,
    // and a few items are stray steps or lines of zero length.
    task automatic random_lines(input int quota);
        req_t r;
        bit made;
        int done, pick, steps, fx, fy;
        done = 0;
        while (done < quota) begin
            pick = $urandom_range(0, 19);
            r = any_req(REQ_LOAD);
            if (pick >= 18) begin
                r.req_type = REQ_STEP;
                issue(r, CHK_MODEL, '0, made);
                if (made) done++;
                continue;
            end
            // The two lowest picks keep fully random endpoints: long lines.
            if (pick >= 2) begin
                fx = near_edge(vp_width);
                fy = near_edge(vp_height);
                r.from_x = fx[CB-1:0];
                r.from_y = fy[CB-1:0];
                if (pick >= 16) begin
                    r.to_x = r.from_x;
                    r.to_y = r.from_y;
                end else begin
                    fx = fit(fx + int'($urandom_range(0, 40)) - 20);
                    fy = fit(fy + int'($urandom_range(0, 40)) - 20);
                    r.to_x = fx[CB-1:0];
                    r.to_y = fy[CB-1:0];
                end
            end
            issue(r, CHK_MODEL, '0, made);
            done++;
            steps = 0;
            if (line_active) steps = int'($signed(major_stop)) - int'($signed(major_pos));
            if (steps > 64) steps = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0: steps = $urandom_range(0, steps);
                1: steps = steps + $urandom_range(1, 2);
                default: ;
            endcase
            repeat (steps) begin
                issue(any_req(REQ_STEP), CHK_MODEL, '0, made);
                if (made) done++;
            end
        end
    endtask

    // The receiver stalls at random, except in the steady phase.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Each pixel taken is matched against the oldest prediction.
    always @(posedge aclk) begin : pixel_check
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                $error("pixel with none predicted: x=%0d y=%0d", m_pixel_x, m_pixel_y);
                mismatches++;
            end else begin
                want = pixels_due.pop_front();
                if (m_pixel_x !== want.x) begin
                    $error("pixel_x: expected %0d, got %0d", want.x, m_pixel_x);
                    mismatches++;
                end
                if (m_pixel_y !== want.y) begin
                    $error("pixel_y: expected %0d, got %0d", want.y, m_pixel_y);
                    mismatches++;
                end
                if (m_pixel_color !== want.color) begin
                    $error("pixel_color: expected %h, got %h", want.color, m_pixel_color);
                    mismatches++;
                end
                if (m_in_view !== want.in_view) begin
                    $error("in_view: expected %b, got %b", want.in_view, m_in_view);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        bit made;
        // A step with nothing loaded since reset gives no pixel.
        directed_rows[0]  = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_NONE,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        // A shallow line of three pixels, fully in view.
        directed_rows[1]  = mk_row(REQ_LOAD, 0, 0, 3, 1, 24'hFF0000, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[2]  = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   0, 0, 24'hFF0000, 1'b1, 1'b0);
        directed_rows[3]  = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   1, 0, 24'hFF0000, 1'b1, 1'b0);
        directed_rows[4]  = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   2, 1, 24'hFF0000, 1'b1, 1'b1);
        // The line is finished, so a further step gives nothing.
        directed_rows[5]  = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_NONE,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        // Corner to corner across the whole range: a diagonal is not steep.
        directed_rows[6]  = mk_row(REQ_LOAD, CMIN, CMIN, CMAX, CMAX, 24'h000000, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[7]  = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   CMIN, CMIN, 24'h000000, 1'b0, 1'b0);
        directed_rows[8]  = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        // A load while that line is still active drops it. The new line is
        // steep and given top end first, so it is swapped and reordered.
        directed_rows[9]  = mk_row(REQ_LOAD, 5, CMAX, 5, CMAX - 2, 24'hFFFFFF, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[10] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   5, CMAX - 2, 24'hFFFFFF, 1'b0, 1'b0);
        directed_rows[11] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   5, CMAX - 1, 24'hFFFFFF, 1'b0, 1'b1);
        // Equal endpoints make a line with no pixels.
        directed_rows[12] = mk_row(REQ_LOAD, 7, 3, 7, 3, 24'h00FF00, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[13] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_NONE,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        // A run of one: a single pixel that is also the last.
        directed_rows[14] = mk_row(REQ_LOAD, CMAX, 0, CMAX - 1, 0, 24'h0000FF, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[15] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   CMAX - 1, 0, 24'h0000FF, 1'b0, 1'b1);
        // Steep, with the cross coordinate falling along the run.
        directed_rows[16] = mk_row(REQ_LOAD, 0, 10, 3, 0, 24'h808080, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[17] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[18] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[19] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        // Straddles the right edge of the 640 by 480 view after reset.
        directed_rows[20] = mk_row(REQ_LOAD, 639, 479, 641, 479, 24'h123456, CHK_MODEL,
                                   0, 0, 24'h000000, 1'b0, 1'b0);
        directed_rows[21] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   639, 479, 24'h123456, 1'b1, 1'b0);
        directed_rows[22] = mk_row(REQ_STEP, 0, 0, 0, 0, 24'h000000, CHK_PIXEL,
                                   640, 479, 24'h123456, 1'b0, 1'b1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            issue(directed_rows[i].req, directed_rows[i].chk, directed_rows[i].px, made);
        end

        // Phase zero keeps the viewport from reset; the others rewrite both
        // registers once the block has gone quiet.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain(SETTLE_CYCLES);
                case (ph)
                    1: write_viewport(12'd1, 12'd1);
                    // A size of zero: nothing is in view.
                    2: write_viewport(12'd0, 12'd0);
                    3: write_viewport(12'd4095, 12'd4095);
                    4: write_viewport(VIEW_BITS'($urandom_range(1, 2048)),
                                      VIEW_BITS'($urandom_range(1, 2048)));
                    default: write_viewport(12'd2047, 12'd1);
                endcase
            end
            steady = (ph == 3);
            random_lines(PHASE_QUOTA);
            s_valid <= 1'b0;
        end
        steady = 1'b0;

        drain(DRAIN_CYCLES);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
